// File: rtl/core/bptc_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bptc_pkg
// Shared types, codes and helpers for the pressure/temperature compensation.
// ----------------------------------------------------------------------------
package bptc_pkg;

  localparam int unsigned DataW = 32;

  typedef struct packed {
    logic [15:0] raw_temperature;
    logic [23:0] raw_pressure_bytes;
  } in_t;

  typedef struct packed {
    logic signed [15:0] temperature_tenths;
    logic [16:0]        pressure_pa;
    logic [1:0]         status;
  } out_t;

  // status codes
  localparam logic [1:0] StOk      = 2'd0;
  localparam logic [1:0] StTempDiv = 2'd1;
  localparam logic [1:0] StPresDiv = 2'd2;
  localparam logic [1:0] StSat     = 2'd3;

  // configuration register indexes
  localparam logic [2:0] RegAc1Ac2 = 3'd0;
  localparam logic [2:0] RegAc3Ac4 = 3'd1;
  localparam logic [2:0] RegAc5Ac6 = 3'd2;
  localparam logic [2:0] RegB1B2   = 3'd3;
  localparam logic [2:0] RegMcMd   = 3'd4;
  localparam logic [2:0] RegOss    = 3'd5;

  localparam logic [1:0] OssReset = 2'd3;

  function automatic logic [31:0] sx16(input logic [15:0] x);
    sx16 = {{16{x[15]}}, x};
  endfunction

  function automatic logic [31:0] asr(input logic [31:0] v, input logic [4:0] s);
    asr = $unsigned($signed(v) >>> s);
  endfunction

endpackage

// File: rtl/core/baro_pressure_temp_compensation.sv
`timescale 1ns / 1ps
// Each accepted sample passes S0 to S2, the temperature divider, S3 to S9, the
// pressure divider, S10, S11 and the done/result register before done_o rises.
// Throughput: one sample per cycle; busy_o stays low, start_i is taken every cycle.
// The pipeline depth is set by the two 32-stage dividers (temperature and pressure) plus
// the multiplier stages around them. Reset clears valid bits and loads the
// coefficient reset values; results are not stalled by the receiver.
// ----------------------------------------------------------------------------
// baro_pressure_temp_compensation
// Integer pressure/temperature compensation of a barometric sensor reading.
// ----------------------------------------------------------------------------
module baro_pressure_temp_compensation (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          start_i,
  output logic          busy_o,
  input  bptc_pkg::in_t in_data_i,
  output logic          done_o,
  output bptc_pkg::out_t result_o,
  input  logic          cfg_we_i,
  input  logic [2:0]    cfg_idx_i,
  input  logic [31:0]   cfg_wdata_i
);
  import bptc_pkg::*;

  localparam int unsigned Side1W = 32 + 1 + 1 + 24;
  localparam int unsigned Side2W = 32 + 1 + 1 + 1;

  // ---------------- configuration ----------------
  logic [31:0] ac12_q, ac34_q, ac56_q, b12_q, mcmd_q;
  logic [1:0]  oss_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ac12_q <= '0;
      ac34_q <= '0;
      ac56_q <= '0;
      b12_q  <= '0;
      mcmd_q <= '0;
      oss_q  <= OssReset;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        RegAc1Ac2: ac12_q <= cfg_wdata_i;
        RegAc3Ac4: ac34_q <= cfg_wdata_i;
        RegAc5Ac6: ac56_q <= cfg_wdata_i;
        RegB1B2:   b12_q  <= cfg_wdata_i;
        RegMcMd:   mcmd_q <= cfg_wdata_i;
        RegOss:    oss_q  <= cfg_wdata_i[1:0];
        default: ;
      endcase
    end
  end

  logic [31:0] ac1, ac2, ac3, ac4, ac5, ac6, b1, b2, mc, md;
  assign ac1 = sx16(ac12_q[31:16]);
  assign ac2 = sx16(ac12_q[15:0]);
  assign ac3 = sx16(ac34_q[31:16]);
  assign ac4 = {16'd0, ac34_q[15:0]};
  assign ac5 = {16'd0, ac56_q[31:16]};
  assign ac6 = {16'd0, ac56_q[15:0]};
  assign b1  = sx16(b12_q[31:16]);
  assign b2  = sx16(b12_q[15:0]);
  assign mc  = sx16(mcmd_q[31:16]);
  assign md  = sx16(mcmd_q[15:0]);

  assign busy_o = 1'b0;

  // ---------------- S0: capture, raw pressure shift ----------------
  logic        v0_q;
  logic [15:0] ut0_q;
  logic [23:0] up0_q;
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) v0_q <= 1'b0;
    else         v0_q <= start_i;
  end
  always_ff @(posedge clk_i) begin
    ut0_q <= in_data_i.raw_temperature;
    up0_q <= in_data_i.raw_pressure_bytes >> (4'd8 - {2'b00, oss_q});
  end

  // ---------------- S1: (UT - AC6) * AC5 ----------------
  logic        v1_q;
  logic [31:0] m1_q;
  logic [23:0] up1_q;
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) v1_q <= 1'b0;
    else         v1_q <= v0_q;
  end
  always_ff @(posedge clk_i) begin
    m1_q  <= ({16'd0, ut0_q} - ac6) * ac5;
    up1_q <= up0_q;
  end

  // ---------------- S2: X1, divisor, operand magnitudes ----------------
  logic [31:0] x1_s2, den_s2, mcs_s2;
  assign x1_s2  = asr(m1_q, 5'd15);
  assign den_s2 = x1_s2 + md;
  assign mcs_s2 = mc << 11;

  logic        v2_q;
  logic [31:0] ma2_q, mb2_q;
  logic [Side1W-1:0] sd2_q;
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) v2_q <= 1'b0;
    else         v2_q <= v1_q;
  end
  always_ff @(posedge clk_i) begin
    ma2_q <= mcs_s2[31] ? 32'd0 - mcs_s2 : mcs_s2;
    mb2_q <= den_s2[31] ? 32'd0 - den_s2 : den_s2;
    sd2_q <= {x1_s2, mcs_s2[31] ^ den_s2[31], den_s2 == 32'd0, up1_q};
  end

  // temperature divider: X2 = (MC << 11) / (X1 + MD)
  logic              vd1;
  logic [31:0]       qd1;
  logic [Side1W-1:0] sd1;
  bptc_div #(.W(DataW), .SW(Side1W)) u_div_t (
    .clk_i, .rst_ni,
    .in_valid_i (v2_q), .dividend_i (ma2_q), .divisor_i (mb2_q), .side_i (sd2_q),
    .out_valid_o(vd1),  .quotient_o (qd1),   .side_o    (sd1)
  );

  // ---------------- S3: B5, B6 ----------------
  logic [31:0] x2_s3, b5_s3;
  assign x2_s3 = sd1[25] ? 32'd0 - qd1 : qd1;
  assign b5_s3 = sd1[57:26] + x2_s3;

  logic        v3_q, zt3_q;
  logic [31:0] b5_3_q, b6_3_q;
  logic [23:0] up3_q;
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) v3_q <= 1'b0;
    else         v3_q <= vd1;
  end
  always_ff @(posedge clk_i) begin
    zt3_q  <= sd1[24];
    b5_3_q <= b5_s3;
    b6_3_q <= b5_s3 - 32'd4000;
    up3_q  <= sd1[23:0];
  end

  // ---------------- S4: B6 products ----------------
  logic        v4_q, zt4_q;
  logic [31:0] b5_4_q, sqp4_q, pa4_q, pb4_q;
  logic [23:0] up4_q;
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) v4_q <= 1'b0;
    else         v4_q <= v3_q;
  end
  always_ff @(posedge clk_i) begin
    zt4_q  <= zt3_q;
    b5_4_q <= b5_3_q;
    sqp4_q <= b6_3_q * b6_3_q;
    pa4_q  <= ac2 * b6_3_q;
    pb4_q  <= ac3 * b6_3_q;
    up4_q  <= up3_q;
  end

  // ---------------- S5: shifts ----------------
  logic        v5_q, zt5_q;
  logic [31:0] b5_5_q, sq5_q, xa5_q, xc5_q;
  logic [23:0] up5_q;
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) v5_q <= 1'b0;
    else         v5_q <= v4_q;
  end
  always_ff @(posedge clk_i) begin
    zt5_q  <= zt4_q;
    b5_5_q <= b5_4_q;
    sq5_q  <= asr(sqp4_q, 5'd12);
    xa5_q  <= asr(pa4_q, 5'd11);
    xc5_q  <= asr(pb4_q, 5'd13);
    up5_q  <= up4_q;
  end

  // ---------------- S6: B2*sq, B1*sq ----------------
  logic        v6_q, zt6_q;
  logic [31:0] b5_6_q, m6_q, n6_q, xa6_q, xc6_q;
  logic [23:0] up6_q;
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) v6_q <= 1'b0;
    else         v6_q <= v5_q;
  end
  always_ff @(posedge clk_i) begin
    zt6_q  <= zt5_q;
    b5_6_q <= b5_5_q;
    m6_q   <= b2 * sq5_q;
    n6_q   <= b1 * sq5_q;
    xa6_q  <= xa5_q;
    xc6_q  <= xc5_q;
    up6_q  <= up5_q;
  end

  // ---------------- S7: B3 and X3 for B4 ----------------
  logic [31:0] x3a_s7, b3_s7, x3b_s7;
  assign x3a_s7 = asr(m6_q, 5'd11) + xa6_q;
  assign b3_s7  = asr(((ac1 << 2) + x3a_s7 << oss_q) + 32'd2, 5'd2);
  assign x3b_s7 = asr(xc6_q + asr(n6_q, 5'd16) + 32'd2, 5'd2);

  logic        v7_q, zt7_q;
  logic [31:0] b5_7_q, b3_7_q, x3_7_q;
  logic [23:0] up7_q;
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) v7_q <= 1'b0;
    else         v7_q <= v6_q;
  end
  always_ff @(posedge clk_i) begin
    zt7_q  <= zt6_q;
    b5_7_q <= b5_6_q;
    b3_7_q <= b3_s7;
    x3_7_q <= x3b_s7;
    up7_q  <= up6_q;
  end

  // ---------------- S8: B4 product, UP - B3 ----------------
  logic        v8_q, zt8_q;
  logic [31:0] b5_8_q, b4p8_q, dif8_q;
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) v8_q <= 1'b0;
    else         v8_q <= v7_q;
  end
  always_ff @(posedge clk_i) begin
    zt8_q  <= zt7_q;
    b5_8_q <= b5_7_q;
    b4p8_q <= ac4 * (x3_7_q + 32'd32768);
    dif8_q <= {8'd0, up7_q} - b3_7_q;
  end

  // ---------------- S9: B4, B7 ----------------
  logic [31:0] b4_s9;
  assign b4_s9 = b4p8_q >> 15;

  logic        v9_q, zt9_q, zp9_q;
  logic [31:0] b5_9_q, b4_9_q, b7_9_q;
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) v9_q <= 1'b0;
    else         v9_q <= v8_q;
  end
  always_ff @(posedge clk_i) begin
    zt9_q  <= zt8_q;
    zp9_q  <= b4_s9 == 32'd0;
    b5_9_q <= b5_8_q;
    b4_9_q <= b4_s9;
    b7_9_q <= dif8_q * (32'd50000 >> oss_q);
  end

  // pressure divider: small B7 doubles before, large B7 doubles after
  logic              vd2;
  logic [31:0]       qd2;
  logic [Side2W-1:0] sd2;
  bptc_div #(.W(DataW), .SW(Side2W)) u_div_p (
    .clk_i, .rst_ni,
    .in_valid_i (v9_q),
    .dividend_i (b7_9_q[31] ? b7_9_q : b7_9_q << 1),
    .divisor_i  (b4_9_q),
    .side_i     ({b5_9_q, zt9_q, zp9_q, b7_9_q[31]}),
    .out_valid_o(vd2), .quotient_o(qd2), .side_o(sd2)
  );

  // ---------------- S10: correction products ----------------
  logic [31:0] p_s10, x1_s10;
  assign p_s10  = sd2[0] ? qd2 << 1 : qd2;
  assign x1_s10 = asr(p_s10, 5'd8);

  logic        v10_q, zt10_q, zp10_q;
  logic [31:0] b5_10_q, p10_q, sqr10_q, x2p10_q;
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) v10_q <= 1'b0;
    else         v10_q <= vd2;
  end
  always_ff @(posedge clk_i) begin
    zt10_q  <= sd2[2];
    zp10_q  <= sd2[1];
    b5_10_q <= sd2[34:3];
    p10_q   <= p_s10;
    sqr10_q <= x1_s10 * x1_s10;
    x2p10_q <= (32'd0 - 32'd7357) * p_s10;
  end

  // ---------------- S11: * 3038 ----------------
  logic        v11_q, zt11_q, zp11_q;
  logic [31:0] b5_11_q, p11_q, t11_q, x2_11_q;
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) v11_q <= 1'b0;
    else         v11_q <= v10_q;
  end
  always_ff @(posedge clk_i) begin
    zt11_q  <= zt10_q;
    zp11_q  <= zp10_q;
    b5_11_q <= b5_10_q;
    p11_q   <= p10_q;
    t11_q   <= sqr10_q * 32'd3038;
    x2_11_q <= asr(x2p10_q, 5'd16);
  end

  // ---------------- S12: final sum, saturation, status ----------------
  logic [31:0] p_fin, t_fin;
  logic        t_hi, t_lo, p_neg, p_hi;
  out_t        res_d;
  assign p_fin = p11_q + asr(asr(t11_q, 5'd16) + x2_11_q + 32'd3791, 5'd4);
  assign t_fin = asr(b5_11_q + 32'd8, 5'd4);
  assign t_hi  = !t_fin[31] && (t_fin[30:15] != 16'd0);
  assign t_lo  = t_fin[31] && (t_fin[30:15] != 16'hFFFF);
  assign p_neg = p_fin[31];
  assign p_hi  = !p_fin[31] && (p_fin[30:17] != 14'd0);

  always_comb begin
    res_d.temperature_tenths = t_hi ? 16'sh7FFF : t_lo ? 16'sh8000 : t_fin[15:0];
    res_d.pressure_pa        = p_neg ? 17'd0 : p_hi ? 17'h1FFFF : p_fin[16:0];
    res_d.status             = (t_hi || t_lo || p_neg || p_hi) ? StSat : StOk;
    if (zt11_q) begin
      res_d = '0;
      res_d.status = StTempDiv;
    end else if (zp11_q) begin
      res_d = '0;
      res_d.status = StPresDiv;
    end
  end

  logic done_q;
  out_t res_q;
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) done_q <= 1'b0;
    else         done_q <= v11_q;
  end
  always_ff @(posedge clk_i) begin
    res_q <= res_d;
  end

  assign done_o   = done_q;
  assign result_o = res_q;

endmodule

// File: rtl/core/bptc_div.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bptc_div
// Pipelined unsigned restoring divider, one quotient bit per stage.
// ----------------------------------------------------------------------------
module bptc_div #(
  parameter int unsigned W  = 32,
  parameter int unsigned SW = 8
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          in_valid_i,
  input  logic [W-1:0]  dividend_i,
  input  logic [W-1:0]  divisor_i,
  input  logic [SW-1:0] side_i,
  output logic          out_valid_o,
  output logic [W-1:0]  quotient_o,
  output logic [SW-1:0] side_o
);

  logic          v_q   [W];
  logic [W-1:0]  rem_q [W];
  logic [W-1:0]  dq_q  [W];
  logic [W-1:0]  dvs_q [W];
  logic [SW-1:0] sd_q  [W];

  for (genvar i = 0; i < W; i++) begin : g_st
    logic          vin;
    logic [W-1:0]  rem_in, dq_in, dvs_in;
    logic [SW-1:0] sd_in;
    logic [W:0]    trial;

    if (i == 0) begin : g_first
      assign vin    = in_valid_i;
      assign rem_in = '0;
      assign dq_in  = dividend_i;
      assign dvs_in = divisor_i;
      assign sd_in  = side_i;
    end else begin : g_next
      assign vin    = v_q[i-1];
      assign rem_in = rem_q[i-1];
      assign dq_in  = dq_q[i-1];
      assign dvs_in = dvs_q[i-1];
      assign sd_in  = sd_q[i-1];
    end

    // sign bit of trial set means the divisor does not fit
    assign trial = {rem_in, dq_in[W-1]} - {1'b0, dvs_in};

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        v_q[i] <= 1'b0;
      end else begin
        v_q[i] <= vin;
      end
    end

    always_ff @(posedge clk_i) begin
      rem_q[i] <= trial[W] ? {rem_in[W-2:0], dq_in[W-1]} : trial[W-1:0];
      dq_q[i]  <= {dq_in[W-2:0], ~trial[W]};
      dvs_q[i] <= dvs_in;
      sd_q[i]  <= sd_in;
    end
  end

  assign out_valid_o = v_q[W-1];
  assign quotient_o  = dq_q[W-1];
  assign side_o      = sd_q[W-1];

endmodule

// File: sim/bptc_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bptc_checker
// Watches the sample and result channels and the register writes, computes
// the compensated temperature and pressure of each accepted sample, and
// compares each result strobe with the oldest pending computed value.
// ----------------------------------------------------------------------------
module bptc_checker (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           start_i,
  input  logic           busy_i,
  input  bptc_pkg::in_t  in_data_i,
  input  logic           done_i,
  input  bptc_pkg::out_t result_i,
  input  logic           cfg_we_i,
  input  logic [2:0]     cfg_idx_i,
  input  logic [31:0]    cfg_wdata_i,
  output int             errors_o,
  output int             pending_o
);
  import bptc_pkg::*;

  logic [31:0] ac1_ac2, ac3_ac4, ac5_ac6, b1_b2, mc_md;
  logic [1:0]  oss;
  out_t        comp_q[$];

  function automatic logic [31:0] ext16(logic [15:0] x);
    return {{16{x[15]}}, x};
  endfunction

  function automatic logic [31:0] sra(logic [31:0] v, int s);
    return $unsigned($signed(v) >>> s);
  endfunction

  function automatic logic [31:0] div_trunc(logic [31:0] a, logic [31:0] b);
    logic [31:0] ma, mb, q;
    ma = a[31] ? -a : a;
    mb = b[31] ? -b : b;
    q  = ma / mb;
    return (a[31] != b[31]) ? -q : q;
  endfunction

  function automatic out_t compensate(in_t s);
    logic [31:0] ac1, ac2, ac3, ac4, ac5, ac6, b1, b2, mc, md;
    logic [31:0] ut, up, x1, x2, x3, den, b5, b6, sq, b3, b4, b7, p, tw;
    out_t r;
    ac1 = ext16(ac1_ac2[31:16]); ac2 = ext16(ac1_ac2[15:0]);
    ac3 = ext16(ac3_ac4[31:16]); ac4 = {16'd0, ac3_ac4[15:0]};
    ac5 = {16'd0, ac5_ac6[31:16]}; ac6 = {16'd0, ac5_ac6[15:0]};
    b1 = ext16(b1_b2[31:16]); b2 = ext16(b1_b2[15:0]);
    mc = ext16(mc_md[31:16]); md = ext16(mc_md[15:0]);
    ut = {16'd0, s.raw_temperature};
    up = {8'd0, s.raw_pressure_bytes} >> (8 - oss);
    r = '0;
    x1 = sra((ut - ac6) * ac5, 15);
    den = x1 + md;
    if (den == 0) begin
      r.status = StTempDiv;
      return r;
    end
    x2 = div_trunc(mc << 11, den);
    b5 = x1 + x2;
    b6 = b5 - 32'd4000;
    sq = sra(b6 * b6, 12);
    x1 = sra(b2 * sq, 11);
    x2 = sra(ac2 * b6, 11);
    x3 = x1 + x2;
    b3 = sra(((ac1 * 4 + x3) << oss) + 2, 2);
    x1 = sra(ac3 * b6, 13);
    x2 = sra(b1 * sq, 16);
    x3 = sra(x1 + x2 + 2, 2);
    b4 = (ac4 * (x3 + 32'd32768)) >> 15;
    if (b4 == 0) begin
      r.status = StPresDiv;
      return r;
    end
    b7 = (up - b3) * (32'd50000 >> oss);
    p = !b7[31] ? (b7 * 2) / b4 : (b7 / b4) * 2;
    x1 = sra(p, 8);
    x1 = x1 * x1;
    x1 = sra(x1 * 32'd3038, 16);
    x2 = sra(-32'd7357 * p, 16);
    p = p + sra(x1 + x2 + 32'd3791, 4);
    r.status = StOk;
    tw = sra(b5 + 8, 4);
    if ($signed(tw) > 32767) begin
      r.temperature_tenths = 16'sh7fff; r.status = StSat;
    end else if ($signed(tw) < -32768) begin
      r.temperature_tenths = 16'sh8000; r.status = StSat;
    end else begin
      r.temperature_tenths = tw[15:0];
    end
    if ($signed(p) < 0) begin
      r.pressure_pa = '0; r.status = StSat;
    end else if ($signed(p) > 131071) begin
      r.pressure_pa = '1; r.status = StSat;
    end else begin
      r.pressure_pa = p[16:0];
    end
    return r;
  endfunction

  assign pending_o = comp_q.size();

  always_ff @(posedge clk_i or negedge rst_ni) begin
    out_t e;
    if (!rst_ni) begin
      ac1_ac2 <= '0; ac3_ac4 <= '0; ac5_ac6 <= '0; b1_b2 <= '0; mc_md <= '0;
      oss <= OssReset;
      errors_o <= 0;
      comp_q.delete();
    end else begin
      // result first: a sample taken this edge cannot finish in the same cycle
      if (done_i) begin
        if (comp_q.size() == 0) begin
          $display("%0t: unexpected result %h", $time, result_i);
          errors_o <= errors_o + 1;
        end else begin
          e = comp_q.pop_front();
          if (e.temperature_tenths !== result_i.temperature_tenths
              || e.pressure_pa !== result_i.pressure_pa
              || e.status !== result_i.status) begin
            $display("%0t: mismatch expected t=%0d p=%0d st=%0d got t=%0d p=%0d st=%0d",
                     $time, e.temperature_tenths, e.pressure_pa, e.status,
                     result_i.temperature_tenths, result_i.pressure_pa, result_i.status);
            errors_o <= errors_o + 1;
          end
        end
      end
      if (start_i && !busy_i) comp_q.push_back(compensate(in_data_i));
      if (cfg_we_i) begin
        case (cfg_idx_i)
          RegAc1Ac2: ac1_ac2 <= cfg_wdata_i;
          RegAc3Ac4: ac3_ac4 <= cfg_wdata_i;
          RegAc5Ac6: ac5_ac6 <= cfg_wdata_i;
          RegB1B2:   b1_b2   <= cfg_wdata_i;
          RegMcMd:   mc_md   <= cfg_wdata_i;
          RegOss:    oss     <= cfg_wdata_i[1:0];
          default: ;
        endcase
      end
    end
  end

endmodule

// File: sim/baro_pressure_temp_compensation_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// baro_pressure_temp_compensation_tb
// Drives samples through the compensation block under several coefficient
// sets; a checker beside the block computes and compares every result.
// ----------------------------------------------------------------------------
module baro_pressure_temp_compensation_tb;
  import bptc_pkg::*;

  localparam int CycleLimit = 200000;
  localparam int Drain      = 120;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        start_i = 1'b0;
  logic        busy_o;
  in_t         in_data_i = '0;
  logic        done_o;
  out_t        result_o;
  logic        cfg_we_i = 1'b0;
  logic [2:0]  cfg_idx_i = '0;
  logic [31:0] cfg_wdata_i = '0;
  int          errors, pending;
  int          cycles = 0;
  bit          calm = 1'b0;  // no idling near the end

  always #5 clk_i = ~clk_i;

  baro_pressure_temp_compensation i_dut (
    .clk_i, .rst_ni, .start_i, .busy_o, .in_data_i, .done_o, .result_o,
    .cfg_we_i, .cfg_idx_i, .cfg_wdata_i
  );

  bptc_checker i_checker (
    .clk_i, .rst_ni, .start_i, .busy_i(busy_o), .in_data_i, .done_i(done_o),
    .result_i(result_o), .cfg_we_i, .cfg_idx_i, .cfg_wdata_i,
    .errors_o(errors), .pending_o(pending)
  );

  // watchdog
  always @(posedge clk_i) begin
    cycles <= cycles + 1;
    if (cycles > CycleLimit) begin
      $display("FAIL");
      $finish;
    end
  end

  task automatic cfg_write(logic [2:0] idx, logic [31:0] val);
    cfg_we_i <= 1'b1; cfg_idx_i <= idx; cfg_wdata_i <= val;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
  endtask

  // wait until every result is back, then let the pipe go quiet
  task automatic drain_pipe();
    start_i <= 1'b0;
    @(posedge clk_i);
    while (pending != 0) @(posedge clk_i);
    repeat (Drain) @(posedge clk_i);
  endtask

  // one sample transfer; random gaps unless in the calm tail
  task automatic send_sample(logic [15:0] ut, logic [23:0] raw);
    int gap;
    if (!calm && $urandom_range(0, 5) == 0) begin
      gap = $urandom_range(1, 5);
      start_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    start_i <= 1'b1;
    in_data_i <= '{raw_temperature: ut, raw_pressure_bytes: raw};
    @(posedge clk_i);
    while (busy_o) @(posedge clk_i);
  endtask

  // realistic coefficient set, jittered; occasionally fully random
  task automatic load_coefs(bit wild, logic [1:0] os);
    logic [15:0] ac1, ac2, ac3, ac4, ac5, ac6, b1, b2, mc, md;
    if (wild) begin
      cfg_write(RegAc1Ac2, $urandom()); cfg_write(RegAc3Ac4, $urandom());
      cfg_write(RegAc5Ac6, $urandom()); cfg_write(RegB1B2, $urandom());
      cfg_write(RegMcMd, $urandom());
    end else begin
      ac1 = 16'(16'd408 + $urandom_range(0, 200));
      ac2 = 16'(-16'sd72 + $urandom_range(0, 40));
      ac3 = 16'(-16'sd14383 + $urandom_range(0, 400));
      ac4 = 16'(16'd32741 + $urandom_range(0, 400));
      ac5 = 16'(16'd32757 - $urandom_range(0, 400));
      ac6 = 16'(16'd23153 + $urandom_range(0, 400));
      b1 = 16'(16'd6190 + $urandom_range(0, 200));
      b2 = 16'(16'd4 + $urandom_range(0, 20));
      mc = 16'(-16'sd8711 + $urandom_range(0, 200));
      md = 16'(16'd2868 + $urandom_range(0, 200));
      cfg_write(RegAc1Ac2, {ac1, ac2}); cfg_write(RegAc3Ac4, {ac3, ac4});
      cfg_write(RegAc5Ac6, {ac5, ac6}); cfg_write(RegB1B2, {b1, b2});
      cfg_write(RegMcMd, {mc, md});
    end
    cfg_write(RegOss, {30'd0, os});
  endtask

  initial begin
    int phase, n;
    repeat (4) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // reset coefficients: temperature divisor is zero
    send_sample(16'h0000, 24'h000000);
    send_sample(16'hffff, 24'hffffff);
    drain_pipe();

    // pressure divisor zero: AC4 = 0, MD nonzero
    cfg_write(RegMcMd, 32'h0000_0001);
    send_sample(16'd27898, 24'h5d2300);
    drain_pipe();

    // directed extremes with a typical set, every oversampling value
    for (int os = 0; os < 4; os++) begin
      load_coefs(1'b0, os[1:0]);
      send_sample(16'd27898, 24'h5d2300);
      send_sample(16'h0000, 24'h000000);
      send_sample(16'hffff, 24'hffffff);
      send_sample(16'h8000, 24'h800000);
      send_sample(16'h7fff, 24'h7fffff);
      drain_pipe();
    end

    // extreme coefficient words: all ones and sign-bit patterns
    cfg_write(RegAc1Ac2, 32'hffff_ffff); cfg_write(RegAc3Ac4, 32'h8000_ffff);
    cfg_write(RegAc5Ac6, 32'hffff_ffff); cfg_write(RegB1B2, 32'h7fff_8000);
    cfg_write(RegMcMd, 32'h8000_7fff); cfg_write(RegOss, 32'd0);
    send_sample(16'h0000, 24'hffffff);
    send_sample(16'hffff, 24'h000000);
    send_sample(16'h5555, 24'haaaaaa);
    drain_pipe();

    // random phases, one deliberate full drain between each
    for (phase = 0; phase < 10; phase++) begin
      load_coefs($urandom_range(0, 3) == 0, 2'($urandom_range(0, 3)));
      if (phase == 9) calm = 1'b1;
      for (n = 0; n < 110; n++) begin
        if ($urandom_range(0, 1))
          send_sample(16'(16'd26000 + $urandom_range(0, 6000)),
                      24'(24'h500000 + $urandom_range(0, 24'h200000)));
        else
          send_sample(16'($urandom()), 24'($urandom()));
      end
      drain_pipe();
    end

    if (errors == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

endmodule
